### sv/rcpp_pkg.sv
`default_nettype none

package rcpp_pkg;

   // Default length of a point set before the arrival index wraps.
   localparam int MAX_POINTS_DEFAULT = 65536;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CONE_COS = 3'd6;

   // Field widths.
   localparam int COORD_W = 24;
   localparam int INDEX_W = 16;
   localparam int DIST_W  = 26;
   localparam int PROJ_W  = 41;   // magnitude of a non-negative projection
   localparam int BEST_W  = 48;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // One classified point as handed from front to back.
   typedef struct packed {
      logic              cone_ok;
      logic [PROJ_W-1:0] proj;
      logic              last;
   } queue_entry_type;

endpackage

`default_nettype wire

### sv/rcpp_front.sv
`default_nettype none

module rcpp_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [rcpp_pkg::COORD_W-1:0]    req_point_x,
   input  wire logic [rcpp_pkg::COORD_W-1:0]    req_point_y,
   input  wire logic [rcpp_pkg::COORD_W-1:0]    req_point_z,
   input  wire logic                            req_last_point,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rcpp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rcpp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                                 push_valid,
   input  wire logic                            push_ready,
   output rcpp_pkg::queue_entry_type            push_entry
);
   import rcpp_pkg::*;

   function automatic logic signed [40:0] mul_off_dir(logic signed [24:0] a,
                                                      logic signed [15:0] b);
      logic signed [40:0] ae;
      logic signed [40:0] be;
      ae = {{16{a[24]}}, a};
      be = {{25{b[15]}}, b};
      return ae * be;
   endfunction

   function automatic logic [48:0] square_off(logic signed [24:0] a);
      logic signed [49:0] ae;
      logic signed [49:0] sq;
      ae = {{25{a[24]}}, a};
      sq = ae * ae;
      return sq[48:0];
   endfunction

   // Configuration registers.
   logic signed [23:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [15:0]        cone_cos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         dir_x_ff    <= 16'sd32767;
         dir_y_ff    <= '0;
         dir_z_ff    <= '0;
         cone_cos_ff <= 16'd65000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            CSR_ORIGIN_Z: origin_z_ff <= csr_wdata;
            CSR_DIR_X:    dir_x_ff    <= csr_wdata[15:0];
            CSR_DIR_Y:    dir_y_ff    <= csr_wdata[15:0];
            CSR_DIR_Z:    dir_z_ff    <= csr_wdata[15:0];
            CSR_CONE_COS: cone_cos_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // The whole pipeline holds while its last stage waits on a full queue.
   logic adv;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;

   assign adv        = !s5_valid_ff || push_ready;
   assign req_ready  = adv;
   assign push_valid = s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 1: offsets from the ray origin.
   logic signed [24:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic signed [24:0] s1_x_in, s1_y_in, s1_z_in;
   logic               s1_last_ff;

   assign s1_x_in = $signed({req_point_x[23], req_point_x}) -
                    $signed({origin_x_ff[23], origin_x_ff});
   assign s1_y_in = $signed({req_point_y[23], req_point_y}) -
                    $signed({origin_y_ff[23], origin_y_ff});
   assign s1_z_in = $signed({req_point_z[23], req_point_z}) -
                    $signed({origin_z_ff[23], origin_z_ff});

   // Stage 2: the three direction products and the three squares.
   logic signed [40:0] s2_px_ff, s2_py_ff, s2_pz_ff;
   logic [48:0]        s2_qx_ff, s2_qy_ff, s2_qz_ff;
   logic               s2_last_ff;

   // Stage 3: projection, squared offset length and squared cosine.
   logic signed [41:0] s3_proj_ff, s3_proj_in;
   logic [49:0]        s3_len2_ff, s3_len2_in;
   logic [31:0]        s3_c2_ff;
   logic               s3_last_ff;

   assign s3_proj_in = {s2_px_ff[40], s2_px_ff} + {s2_py_ff[40], s2_py_ff} +
                       {s2_pz_ff[40], s2_pz_ff};
   assign s3_len2_in = {1'b0, s2_qx_ff} + {1'b0, s2_qy_ff} + {1'b0, s2_qz_ff};

   // Stage 4: partial products of proj^2 and cos^2 * len2.
   logic [PROJ_W-1:0] s3_p;
   logic [19:0]       s3_ph;
   logic [20:0]       s3_pl;
   logic [39:0]       s4_hh_ff;
   logic [40:0]       s4_hl_ff;
   logic [41:0]       s4_ll_ff;
   logic [56:0]       s4_rh_ff, s4_rl_ff;
   logic [PROJ_W-1:0] s4_p_ff;
   logic              s4_neg_ff, s4_last_ff;

   assign s3_p  = s3_proj_ff[PROJ_W-1:0];
   assign s3_ph = s3_p[40:21];
   assign s3_pl = s3_p[20:0];

   // Stage 5: full-width proj^2 and cos^2 * len2.
   logic [81:0]       s5_sq_ff, s5_sq_in;
   logic [81:0]       s5_rhs_ff, s5_rhs_in;
   logic [PROJ_W-1:0] s5_p_ff;
   logic              s5_neg_ff, s5_last_ff;

   assign s5_sq_in  = {s4_hh_ff, 42'd0} + {19'd0, s4_hl_ff, 22'd0} + {40'd0, s4_ll_ff};
   assign s5_rhs_in = {s4_rh_ff, 25'd0} + {25'd0, s4_rl_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff    <= s1_x_in;
         s1_y_ff    <= s1_y_in;
         s1_z_ff    <= s1_z_in;
         s1_last_ff <= req_last_point;

         s2_px_ff   <= mul_off_dir(s1_x_ff, dir_x_ff);
         s2_py_ff   <= mul_off_dir(s1_y_ff, dir_y_ff);
         s2_pz_ff   <= mul_off_dir(s1_z_ff, dir_z_ff);
         s2_qx_ff   <= square_off(s1_x_ff);
         s2_qy_ff   <= square_off(s1_y_ff);
         s2_qz_ff   <= square_off(s1_z_ff);
         s2_last_ff <= s1_last_ff;

         s3_proj_ff <= s3_proj_in;
         s3_len2_ff <= s3_len2_in;
         s3_c2_ff   <= cone_cos_ff * cone_cos_ff;
         s3_last_ff <= s2_last_ff;

         s4_hh_ff   <= s3_ph * s3_ph;
         s4_hl_ff   <= s3_ph * s3_pl;
         s4_ll_ff   <= s3_pl * s3_pl;
         s4_rh_ff   <= s3_c2_ff * s3_len2_ff[49:25];
         s4_rl_ff   <= s3_c2_ff * s3_len2_ff[24:0];
         s4_p_ff    <= s3_p;
         s4_neg_ff  <= s3_proj_ff[41];
         s4_last_ff <= s3_last_ff;

         s5_sq_ff   <= s5_sq_in;
         s5_rhs_ff  <= s5_rhs_in;
         s5_p_ff    <= s4_p_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_last_ff <= s4_last_ff;
      end
   end

   // Inside the cone when 4 * p^2 > cos^2 * |offset|^2 with p non-negative.
   always_comb begin
      push_entry.cone_ok = !s5_neg_ff && ({s5_sq_ff, 2'b00} > {2'b00, s5_rhs_ff});
      push_entry.proj    = s5_p_ff;
      push_entry.last    = s5_last_ff;
   end

endmodule

`default_nettype wire

### sv/rcpp_queue.sv
`default_nettype none

module rcpp_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_valid,
   output logic                            push_ready,
   input  wire rcpp_pkg::queue_entry_type  push_entry,
   output logic                            pop_valid,
   input  wire logic                       pop_ready,
   output rcpp_pkg::queue_entry_type       pop_entry
);
   import rcpp_pkg::*;

   queue_entry_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]        count_ff, count_in;
   logic                        do_push, do_pop;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### sv/rcpp_back.sv
`default_nettype none

module rcpp_back #(
   parameter int MAX_POINTS = rcpp_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          pop_valid,
   output logic                               pop_ready,
   input  wire rcpp_pkg::queue_entry_type     pop_entry,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic [rcpp_pkg::INDEX_W-1:0]       rsp_best_index,
   output logic [rcpp_pkg::DIST_W-1:0]        rsp_best_distance
);
   import rcpp_pkg::*;

   localparam int CNT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_POINTS - 1);

   logic [BEST_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0]  slot_ff, slot_in;
   logic              have_ff, have_in;
   logic [CNT_W-1:0]  count_ff, count_next;
   logic              take, do_pop;

   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [DIST_W-1:0]   rsp_dist_ff, dist_in;

   // A last point needs the output register free; other beats always drain.
   assign pop_ready = !pop_entry.last || !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;

   // Strictly below the best so far, so a tie keeps the earlier point.
   assign take    = pop_entry.cone_ok && ({7'd0, pop_entry.proj} < best_ff);
   assign best_in = take ? {7'd0, pop_entry.proj} : best_ff;
   assign slot_in = take ? count_ff : slot_ff;
   assign have_in = take || have_ff;

   assign count_next = (count_ff == CNT_LAST) ? '0 : count_ff + 1'b1;

   assign dist_in = (|best_in[BEST_W-1:PROJ_W]) ? '1 : best_in[PROJ_W-1:15];

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= '1;
         slot_ff  <= '0;
         have_ff  <= 1'b0;
         count_ff <= '0;
      end else if (do_pop) begin
         if (pop_entry.last) begin
            best_ff  <= '1;
            slot_ff  <= '0;
            have_ff  <= 1'b0;
            count_ff <= '0;
         end else begin
            best_ff  <= best_in;
            slot_ff  <= slot_in;
            have_ff  <= have_in;
            count_ff <= count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_pop && pop_entry.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop && pop_entry.last) begin
         rsp_found_ff <= have_in;
         rsp_index_ff <= have_in ? INDEX_W'(slot_in) : '0;
         rsp_dist_ff  <= have_in ? dist_in : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_best_index    = rsp_index_ff;
   assign rsp_best_distance = rsp_dist_ff;

endmodule

`default_nettype wire

### sv/ray_cone_point_pick_top.sv
`default_nettype none

// Channel  | Dir | Ports
// req      | in  | req_valid, req_ready, req_point_x/y/z, req_last_point
// rsp      | out | rsp_valid, rsp_ready, rsp_found, rsp_best_index, rsp_best_distance
// csr      | in  | csr_valid, csr_ready, csr_index, csr_wdata
//
// One point beat is taken per cycle while the front is not stalled. The front is a
// five-stage arithmetic pipeline that feeds the four-entry queue; the back folds one
// queued point per cycle into the running best while it is not stalled, and the result
// of a last point is registered at the edge that pops it. Reset is synchronous and
// clears the configuration to its defaults and the search. The front stalls only on a
// full queue; the back stalls only on a last point while a previous result has not
// been taken.
module ray_cone_point_pick_top #(
   parameter int MAX_POINTS = rcpp_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [rcpp_pkg::COORD_W-1:0]    req_point_x,
   input  wire logic [rcpp_pkg::COORD_W-1:0]    req_point_y,
   input  wire logic [rcpp_pkg::COORD_W-1:0]    req_point_z,
   input  wire logic                            req_last_point,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_found,
   output logic [rcpp_pkg::INDEX_W-1:0]         rsp_best_index,
   output logic [rcpp_pkg::DIST_W-1:0]          rsp_best_distance,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rcpp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rcpp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rcpp_pkg::*;

   logic            push_valid, push_ready;
   queue_entry_type push_entry;
   logic            pop_valid, pop_ready;
   queue_entry_type pop_entry;

   rcpp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_last_point (req_last_point),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   rcpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rcpp_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance)
   );

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

module tb;
   import rcpp_pkg::*;

   localparam int TB_MAX_POINTS = MAX_POINTS_DEFAULT;
   localparam int RANDOM_ITEMS = 950;
   localparam int DRAIN_CYCLES = 24;
   localparam longint DIST_CAP = (longint'(1) << DIST_W) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;
   localparam logic [15:0] DIR_MAX = 16'h7FFF;
   localparam logic [15:0] DIR_MIN = 16'h8000;
   localparam logic [15:0] COS_RESET = 16'd65000;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  distance;
   } pick_result_type;

   typedef enum int {RSP_OPEN, RSP_COIN, RSP_SPARSE} rsp_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [COORD_W-1:0]    req_point_x = '0;
   logic [COORD_W-1:0]    req_point_y = '0;
   logic [COORD_W-1:0]    req_point_z = '0;
   logic                  req_last_point = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_found;
   logic [INDEX_W-1:0]    rsp_best_index;
   logic [DIST_W-1:0]     rsp_best_distance;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor copy of the ray setup and of the running search.
   longint             ray_org [3];
   longint             ray_dir [3];
   longint             cone_c;
   logic [BEST_W-1:0]  near_proj;
   logic [INDEX_W-1:0] near_slot;
   logic               near_valid;
   int                 arrival;

   pick_result_type pick_expected [$];
   int              mismatches = 0;
   int              burst_left = 0;
   int              rsp_hold_cycles = 0;
   rsp_mode_type    rsp_mode = RSP_OPEN;
   int              mode_left = 0;

   ray_cone_point_pick_top #(.MAX_POINTS(TB_MAX_POINTS)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_best_index   (rsp_best_index),
      .rsp_best_distance(rsp_best_distance),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("ray_cone_point_pick_top test failed");
      $finish;
   end

   function automatic void clear_pick();
      near_proj = '1;
      near_slot = '0;
      near_valid = 1'b0;
      arrival = 0;
   endfunction

   function automatic void reset_prediction();
      ray_org[0] = 0;
      ray_org[1] = 0;
      ray_org[2] = 0;
      ray_dir[0] = longint'(DIR_MAX);
      ray_dir[1] = 0;
      ray_dir[2] = 0;
      cone_c = longint'(COS_RESET);
      clear_pick();
   endfunction

   function automatic void set_register(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_ORIGIN_X: ray_org[0] = longint'($signed(data));
         CSR_ORIGIN_Y: ray_org[1] = longint'($signed(data));
         CSR_ORIGIN_Z: ray_org[2] = longint'($signed(data));
         CSR_DIR_X:    ray_dir[0] = longint'($signed(data[15:0]));
         CSR_DIR_Y:    ray_dir[1] = longint'($signed(data[15:0]));
         CSR_DIR_Z:    ray_dir[2] = longint'($signed(data[15:0]));
         CSR_CONE_COS: cone_c = longint'(data[15:0]);
         default: ;
      endcase
   endfunction

   // Folds one accepted point into the search; a last point yields the pick.
   function automatic void fold_point(input logic [COORD_W-1:0] px, py, pz,
                                      input logic last);
      longint          s [3];
      longint          proj;
      longint          len2;
      longint          whole;
      logic [127:0]    lhs;
      logic [127:0]    rhs;
      logic [127:0]    wide_len;
      pick_result_type r;
      s[0] = longint'($signed(px)) - ray_org[0];
      s[1] = longint'($signed(py)) - ray_org[1];
      s[2] = longint'($signed(pz)) - ray_org[2];
      proj = s[0] * ray_dir[0] + s[1] * ray_dir[1] + s[2] * ray_dir[2];
      if (proj >= 0 && proj < longint'(near_proj)) begin
         len2 = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
         lhs = proj;
         lhs = (lhs * lhs) << 2;
         rhs = cone_c * cone_c;
         wide_len = len2;
         rhs = rhs * wide_len;
         if (lhs > rhs) begin
            near_proj = BEST_W'(proj);
            near_slot = INDEX_W'(arrival);
            near_valid = 1'b1;
         end
      end
      arrival = (arrival + 1 >= TB_MAX_POINTS) ? 0 : arrival + 1;
      if (last) begin
         r = '0;
         if (near_valid) begin
            whole = longint'(near_proj >> 15);
            if (whole > DIST_CAP)
               whole = DIST_CAP;
            r.found = 1'b1;
            r.index = near_slot;
            r.distance = DIST_W'(whole);
         end
         pick_expected.insert(pick_expected.size(), r);
         clear_pick();
      end
   endfunction

   // Receiver: a changing stall pattern, overridden by a long hold when asked.
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         if (mode_left == 0) begin
            rsp_mode = rsp_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(8, 120);
         end
         mode_left = mode_left - 1;
         case (rsp_mode)
            RSP_OPEN: rsp_ready <= 1'b1;
            RSP_COIN: rsp_ready <= 1'($urandom_range(0, 1));
            default:  rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin : check_picks
      pick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pick_expected.size() == 0) begin
            $error("result beat with no pick pending");
            mismatches++;
         end else begin
            want = pick_expected.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               mismatches++;
            end
            if (rsp_best_index !== want.index) begin
               $error("best_index: expected %0d, got %0d", want.index, rsp_best_index);
               mismatches++;
            end
            if (rsp_best_distance !== want.distance) begin
               $error("best_distance: expected %0d, got %0d",
                      want.distance, rsp_best_distance);
               mismatches++;
            end
         end
      end
   end

   task automatic send_point(input logic [COORD_W-1:0] px, py, pz, input logic last);
      int gap;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      req_last_point <= last;
      do @(posedge clock); while (!req_ready);
      fold_point(px, py, pz, last);
      burst_left--;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      set_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_ray(input logic [CSR_DATA_W-1:0] ox, oy, oz, dx, dy, dz, cc);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_ORIGIN_Z, oz);
      csr_write(CSR_DIR_X, dx);
      csr_write(CSR_DIR_Y, dy);
      csr_write(CSR_DIR_Z, dz);
      csr_write(CSR_CONE_COS, cc);
   endtask

   // Stops offering points and lets every pick and the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pick_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A point near the current ray, with lateral jitter growing with distance.
   function automatic void aim_point(output logic [COORD_W-1:0] px, py, pz);
      longint t;
      longint spread;
      longint c [3];
      t = $urandom_range(0, 1 << 20);
      spread = t / 8 + 2;
      for (int i = 0; i < 3; i++)
         c[i] = ray_org[i] + ((t * ray_dir[i]) >>> 15)
                + longint'($urandom_range(0, 2 * spread)) - spread;
      px = COORD_W'(c[0]);
      py = COORD_W'(c[1]);
      pz = COORD_W'(c[2]);
   endfunction

   task automatic randomize_ray();
      logic [CSR_DATA_W-1:0] o [3];
      logic [CSR_DATA_W-1:0] d [3];
      logic [CSR_DATA_W-1:0] cc;
      int axis;
      for (int i = 0; i < 3; i++)
         o[i] = ($urandom_range(0, 2) == 0) ? CSR_DATA_W'($urandom)
              : CSR_DATA_W'(longint'($urandom_range(0, 65535)) - 32768);
      if ($urandom_range(0, 2) == 0) begin
         // Axis-aligned unit direction; the unused upper data bits stay random.
         for (int i = 0; i < 3; i++)
            d[i] = {8'($urandom), 16'h0000};
         axis = $urandom_range(0, 2);
         d[axis] = {8'($urandom), ($urandom_range(0, 1) == 1) ? DIR_MAX : DIR_MIN};
      end else begin
         for (int i = 0; i < 3; i++)
            d[i] = CSR_DATA_W'($urandom);
      end
      case ($urandom_range(0, 3))
         0: cc = '0;
         1: cc = {8'($urandom), 16'hFFFF};
         2: cc = CSR_DATA_W'($urandom_range(55000, 65535));
         default: cc = CSR_DATA_W'($urandom);
      endcase
      write_ray(o[0], o[1], o[2], d[0], d[1], d[2], cc);
      if ($urandom_range(0, 3) == 0)
         csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
   endtask

   task automatic test_reset_defaults();
      send_point(0, 0, 0, 1'b0);
      send_point(-5, 0, 0, 1'b0);
      send_point(100, 0, 0, 1'b0);
      send_point(100, 0, 0, 1'b0);
      send_point(50, 40, 0, 1'b0);
      send_point(200, 3, -2, 1'b1);
      settle();
   endtask

   task automatic test_nothing_found();
      send_point(-7, 9, 1, 1'b1);
      send_point(0, 0, 0, 1'b1);
      settle();
   endtask

   task automatic test_extremes();
      write_ray(COORD_MIN, COORD_MIN, COORD_MIN, {8'hFF, DIR_MAX}, {8'hFF, DIR_MAX},
                {8'hFF, DIR_MAX}, '0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
      settle();
      write_ray(COORD_MAX, COORD_MAX, COORD_MAX, {8'h00, DIR_MIN}, {8'h00, DIR_MIN},
                {8'h00, DIR_MIN}, {8'h00, 16'hFFFF});
      send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      settle();
   endtask

   task automatic test_mid_set_config();
      write_ray('0, '0, '0, {8'h00, DIR_MAX}, '0, '0, {8'h00, COS_RESET});
      send_point(300, 0, 0, 1'b0);
      send_point(-400, 0, 0, 1'b0);
      settle();
      // Flipping the ray mid-set keeps the best so far and judges later points anew.
      csr_write(CSR_DIR_X, {8'h00, DIR_MIN});
      send_point(-100, 0, 0, 1'b1);
      settle();
   endtask

   task automatic test_spare_register();
      csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
      send_point(-70, 1, 1, 1'b1);
      settle();
   endtask

   task automatic test_backpressure();
      write_ray('0, '0, '0, {8'h00, DIR_MAX}, '0, '0, '0);
      rsp_hold_cycles = 300;
      burst_left = 1_000_000;
      repeat (40) begin : short_set
         int len;
         logic [COORD_W-1:0] px, py, pz;
         len = $urandom_range(1, 3);
         for (int k = 0; k < len; k++) begin
            aim_point(px, py, pz);
            send_point(px, py, pz, k == len - 1);
         end
      end
      settle();
   endtask

   task automatic test_random_sets();
      int sent;
      int len;
      logic [COORD_W-1:0] px, py, pz;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         randomize_ray();
         repeat ($urandom_range(2, 6)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 3) == 0) begin
                  px = COORD_W'($urandom);
                  py = COORD_W'($urandom);
                  pz = COORD_W'($urandom);
               end else begin
                  aim_point(px, py, pz);
               end
               send_point(px, py, pz, k == len - 1);
            end
            sent += len;
         end
         settle();
      end
   endtask

   initial begin
      reset_prediction();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_nothing_found();
      test_extremes();
      test_mid_set_config();
      test_spare_register();
      test_backpressure();
      test_random_sets();
      if (mismatches == 0)
         $display("ray_cone_point_pick_top test passed");
      else
         $display("ray_cone_point_pick_top test failed");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
sv/rcpp_pkg.sv
sv/rcpp_front.sv
sv/rcpp_queue.sv
sv/rcpp_back.sv
sv/ray_cone_point_pick_top.sv
verif/tb.sv
